@@ rtl/crcpd_pkg.sv @@
// ============================================================================
// crcpd_pkg
// Shared types and constants for the bit-serial CRC polynomial divider.
// ============================================================================
package crcpd_pkg;

    // Generator limits and register widths
    localparam int MAX_POLY_LEN = 33;
    localparam int REM_W        = MAX_POLY_LEN - 1;
    localparam int REM_IDX_W    = $clog2(REM_W);
    localparam int LEN_W        = 6;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_ADDR_W   = 1;

    // Stream word widths
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 40;

    // Front-to-back queue
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_POLY_LOW_BITS = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_POLY_LEN      = 1'b1;

    // Reset values of the configuration registers
    localparam logic [CFG_DATA_W-1:0] POLY_LOW_BITS_RST = 32'h0000_8005;
    localparam logic [LEN_W-1:0]      POLY_LEN_RST      = 6'd17;

    // Item kinds decided by the front end
    typedef enum logic [1:0] {
        KIND_BIT     = 2'd0,
        KIND_END_CHK = 2'd1,
        KIND_END_GEN = 2'd2
    } t_kind;

    typedef struct packed {
        logic  data_bit;
        t_kind kind;
    } t_item;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] poly_low_bits;
        logic [LEN_W-1:0]      poly_len;
    } t_cfg;

endpackage

@@ rtl/crcpd_front.sv @@
// ============================================================================
// crcpd_front
// Input side: takes stream words, tags each as a plain bit, a check-mode end
// or a generate-mode end, and holds them in a short queue for the back end.
// ============================================================================
module crcpd_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [crcpd_pkg::S_TDATA_W-1:0] i_s_tdata,   // [0] data_bit, rest zero
    input  logic                            i_s_tlast,
    input  logic                            i_s_tuser,   // [0] mode
    output crcpd_pkg::t_item                o_item,
    output logic                            o_item_valid,
    input  logic                            i_item_pop
);
    import crcpd_pkg::*;

    t_item               r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                push;
    logic                pop;
    t_item               item_in;

    // Classify the incoming word
    always_comb begin
        item_in.data_bit = i_s_tdata[0];
        if (!i_s_tlast) begin
            item_in.kind = KIND_BIT;
        end else if (i_s_tuser) begin
            item_in.kind = KIND_END_CHK;
        end else begin
            item_in.kind = KIND_END_GEN;
        end
    end

    assign o_s_tready   = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_queue[r_rd_ptr];
    assign push         = i_s_tvalid && o_s_tready;
    assign pop          = i_item_pop && o_item_valid;

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= item_in;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/crcpd_back.sv @@
// ============================================================================
// crcpd_back
// Division engine: one modulo-2 step per unstalled cycle, a zero-bit flush
// after a generate-mode end, and the output register of the result stream.
// ============================================================================
module crcpd_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  crcpd_pkg::t_cfg                 i_cfg,
    input  crcpd_pkg::t_item                i_item,
    input  logic                            i_item_valid,
    output logic                            o_item_pop,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [0] quotient_bit, [1] quotient_valid, [33:2] remainder, rest zero
    output logic [crcpd_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                            o_m_tlast,   // done_res
    output logic                            o_m_tuser    // [0] error_found
);
    import crcpd_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN = 2'b01,
        ST_PAD = 2'b10
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [REM_W-1:0]   r_rem;
    logic [LEN_W-1:0]   r_seen;
    logic [LEN_W-1:0]   r_pad_cnt;
    logic               r_out_valid;
    logic               r_out_q;
    logic               r_out_qv;
    logic [REM_W-1:0]   r_out_rem;
    logic               r_out_done;
    logic               r_out_err;

    logic               is_pad;
    logic               advance;
    logic               step_en;
    logic [LEN_W-1:0]   eff_len;
    logic [LEN_W-1:0]   w;
    logic [REM_W-1:0]   mask;
    logic [REM_IDX_W-1:0] top_idx;
    logic               step_bit;
    logic [REM_W-1:0]   rem_m;
    logic               q_avail;
    logic               q;
    logic [LEN_W-1:0]   seen_nxt;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   rem_nxt;
    logic               done;
    logic               start_pad;
    logic               err;

    assign is_pad     = (r_state == ST_PAD);
    assign advance    = !r_out_valid || i_m_tready;
    assign step_en    = advance && (is_pad || i_item_valid);
    assign o_item_pop = advance && !is_pad && i_item_valid;

    // Effective generator length and remainder width
    always_comb begin
        if (i_cfg.poly_len < LEN_W'(2)) begin
            eff_len = LEN_W'(2);
        end else if (i_cfg.poly_len > LEN_W'(MAX_POLY_LEN)) begin
            eff_len = LEN_W'(MAX_POLY_LEN);
        end else begin
            eff_len = i_cfg.poly_len;
        end
        w       = eff_len - LEN_W'(1);
        top_idx = REM_IDX_W'(w - LEN_W'(1));
        if (w == LEN_W'(REM_W)) begin
            mask = '1;
        end else begin
            mask = (REM_W'(1) << w) - REM_W'(1);
        end
    end

    // One division step
    always_comb begin
        step_bit = is_pad ? 1'b0 : i_item.data_bit;
        rem_m    = r_rem & mask;
        q_avail  = (r_seen >= w);
        q        = q_avail && rem_m[top_idx];
        seen_nxt = q_avail ? w : r_seen + LEN_W'(1);
        rem_sh   = ({rem_m[REM_W-2:0], step_bit}) & mask;
        rem_nxt  = q ? (rem_sh ^ (i_cfg.poly_low_bits[REM_W-1:0] & mask)) : rem_sh;
        done      = is_pad ? (r_pad_cnt == LEN_W'(1)) : (i_item.kind == KIND_END_CHK);
        start_pad = !is_pad && (i_item.kind == KIND_END_GEN);
        err       = !is_pad && (i_item.kind == KIND_END_CHK) && (rem_nxt != '0);
    end

    // Run / flush sequencing
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (step_en && start_pad) begin
                    n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                if (step_en && done) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    // Control state and division registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_rem       <= '0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (step_en) begin
                if (done) begin
                    r_rem  <= '0;
                    r_seen <= '0;
                end else begin
                    r_rem  <= rem_nxt;
                    r_seen <= seen_nxt;
                end
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Flush counter and output word
    always_ff @(posedge i_clk) begin
        if (step_en) begin
            if (start_pad) begin
                r_pad_cnt <= w;
            end else begin
                r_pad_cnt <= r_pad_cnt - LEN_W'(1);
            end
            r_out_q    <= q;
            r_out_qv   <= q_avail;
            r_out_rem  <= done ? rem_nxt : '0;
            r_out_done <= done;
            r_out_err  <= err;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(M_TDATA_W - REM_W - 2)'(0), r_out_rem, r_out_qv, r_out_q};
    assign o_m_tlast  = r_out_done;
    assign o_m_tuser  = r_out_err;

endmodule

@@ rtl/crc_polynomial_divider.sv @@
// ============================================================================
// crc_polynomial_divider
// Bit-serial modulo-2 long division of a message by a configurable generator.
// ============================================================================
// Usage:
//   Input stream: one message bit per word in tdata[0], tlast on the final
//   bit, tuser = 0 to generate (flush with zeros) or 1 to check a codeword.
//   Output stream: one word per step with the quotient bit and its valid
//   flag; the word with tlast carries the remainder, and tuser flags a
//   nonzero remainder in check mode.
//   Configuration: write poly_low_bits (index 0) or poly_len (index 1)
//   through the write port while the block is idle.
// Timing:
//   A word's first result passes through the input queue and then the
//   output register. One word per cycle is sustained while the receiver
//   takes every result; a generate-mode final word holds the division step
//   unit for its own bit and its zero-bit flush steps, during which the
//   two-entry input queue fills and then holds off input.
// Reset and stall:
//   Reset clears the remainder, bit count, queue and output register and
//   restores poly_low_bits = 0x8005, poly_len = 17. When the receiver
//   stalls, the output word holds and the input queue absorbs two words.
// ============================================================================
module crc_polynomial_divider (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [crcpd_pkg::S_TDATA_W-1:0]  i_s_tdata,   // [0] data_bit, rest zero
    input  logic                             i_s_tlast,   // last
    input  logic                             i_s_tuser,   // [0] mode
    // Output stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [0] quotient_bit, [1] quotient_valid, [33:2] remainder, rest zero
    output logic [crcpd_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic                             o_m_tlast,   // done_res
    output logic                             o_m_tuser,   // [0] error_found
    // Configuration write port
    input  logic                             i_cfg_we,
    input  logic [crcpd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [crcpd_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import crcpd_pkg::*;

    t_cfg  r_cfg;
    t_item item;
    logic  item_valid;
    logic  item_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poly_low_bits <= POLY_LOW_BITS_RST;
            r_cfg.poly_len      <= POLY_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_POLY_LOW_BITS: r_cfg.poly_low_bits <= i_cfg_wdata;
                REG_POLY_LEN:      r_cfg.poly_len      <= i_cfg_wdata[LEN_W-1:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    crcpd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_s_tuser    (i_s_tuser),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_item_pop   (item_pop)
    );

    crcpd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_pop   (item_pop),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tlast    (o_m_tlast),
        .o_m_tuser    (o_m_tuser)
    );

endmodule

@@ rtl/crcpd_checker.sv @@
// ============================================================================
// crcpd_checker
// Port-level checks on the divider's result stream.
// ============================================================================
module crcpd_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [crcpd_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input  logic                             o_m_tlast,
    input  logic                             o_m_tuser
);
    import crcpd_pkg::*;

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("result word changed while stalled");

    // No quotient bit without its valid flag
    a_q_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && !o_m_tdata[1]))
        else $error("quotient bit set without quotient valid");

    // Remainder shows only on the final word of a run
    a_rem_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> (o_m_tdata[REM_W+1:2] == '0))
        else $error("remainder nonzero before end of run");

    // Error flag only on a final word with a nonzero remainder
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast && (o_m_tdata[REM_W+1:2] != '0))
        else $error("error flag without nonzero final remainder");

    // Reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule

bind crc_polynomial_divider crcpd_checker u_crcpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tlast   (o_m_tlast),
    .o_m_tuser   (o_m_tuser)
);

@@ tb/tb_crc_polynomial_divider.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_crc_polynomial_divider
// Self-checking bench for the bit-serial CRC polynomial divider.
// ============================================================================
// A queue of input words feeds a clocked driver. A clocked monitor runs a
// bit-level model of the long division on every accepted input word and
// checks each output word, in order, against the predicted quotient bits,
// remainder and error flag. A short directed section covers generator length
// extremes, single-bit and short runs, and a length change in mid-run.
// Random phases follow: generate runs, check runs on valid or corrupted
// codewords, and noise. Generator settings change between phases, and the
// idle patterns on both streams change with them.
// ============================================================================
module tb_crc_polynomial_divider;
    import crcpd_pkg::*;

    localparam int  CYCLE_LIMIT   = 1_000_000;
    localparam int  TOTAL_WORDS   = 160;
    localparam int  MAX_REPORTS   = 10;
    // Values of the mode flag carried in tuser
    localparam logic MODE_GEN     = 1'b0;
    localparam logic MODE_CHK     = 1'b1;

    typedef struct packed {
        logic data_bit;
        logic last;
        logic mode;
    } in_word_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [LEN_W-1:0] seen;
    } div_state_t;

    typedef struct packed {
        logic             q;
        logic             q_valid;
        logic [REM_W-1:0] rem;
        logic             done;
        logic             err;
    } div_result_t;

    // DUT connections, all driven to known values from time zero
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [S_TDATA_W-1:0]   i_s_tdata   = '0;    // [0] data_bit
    logic                   i_s_tlast   = 1'b0;  // last
    logic                   i_s_tuser   = 1'b0;  // [0] mode
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   o_m_tdata;           // [0] q, [1] q valid, [33:2] remainder
    logic                   o_m_tlast;           // done
    logic                   o_m_tuser;           // [0] error_found
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    crc_polynomial_divider dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Bench copy of the generator registers and the division state
    logic [CFG_DATA_W-1:0] gen_low = POLY_LOW_BITS_RST;
    logic [LEN_W-1:0]      gen_len = POLY_LEN_RST;
    div_state_t            div_st  = '0;

    in_word_t    bits_to_send[$];
    div_result_t div_results_q[$];

    // Idle pattern of the current phase
    bit src_gaps   = 1'b1;
    bit snk_stalls = 1'b1;

    int cycle_cnt      = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int n_queued       = 0;
    int n_words_in     = 0;
    int n_words_out    = 0;
    int n_runs         = 0;
    int n_flagged      = 0;
    int n_cfg_writes   = 0;
    int n_phases       = 0;
    int n_mismatch     = 0;

    always #4 i_clk = ~i_clk;

    function automatic logic rand_bit();
        return $urandom_range(0, 1) != 0;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // Register width in use: generator length clamped to 2..MAX_POLY_LEN, minus one
    function automatic int eff_width(input logic [LEN_W-1:0] len);
        if (len < 2) return 1;
        if (len > MAX_POLY_LEN) return MAX_POLY_LEN - 1;
        return int'(len) - 1;
    endfunction

    // One shift-and-subtract step of the long division
    function automatic div_state_t div_step(input div_state_t s, input logic b,
                                            input logic [CFG_DATA_W-1:0] low,
                                            input logic [LEN_W-1:0] len,
                                            output logic q, output logic q_valid);
        int          w;
        logic [63:0] mask;
        logic [63:0] r;
        w    = eff_width(len);
        mask = (64'd1 << w) - 64'd1;
        r    = {32'd0, s.rem} & mask;
        q       = 1'b0;
        q_valid = 1'b0;
        if (int'(s.seen) >= w) begin
            q       = r[w-1];
            q_valid = 1'b1;
            s.seen  = LEN_W'(w);
        end else begin
            s.seen  = s.seen + 1'b1;
        end
        r = ((r << 1) | {63'd0, b}) & mask;
        if (q) r = r ^ ({32'd0, low} & mask);
        s.rem = r[REM_W-1:0];
        return s;
    endfunction

    // Expected output words for one accepted input word
    function automatic void predict_division(input logic b, input logic last,
                                             input logic mode);
        div_result_t res;
        int          pad;
        res    = '0;
        div_st = div_step(div_st, b, gen_low, gen_len, res.q, res.q_valid);
        if (last) begin
            // generate mode flushes with zero bits
            pad = (mode == MODE_GEN) ? eff_width(gen_len) : 0;
            for (int i = 0; i < pad; i++) begin
                div_results_q.push_back(res);
                res    = '0;
                div_st = div_step(div_st, 1'b0, gen_low, gen_len, res.q, res.q_valid);
            end
            res.rem  = div_st.rem;
            res.done = 1'b1;
            res.err  = (mode == MODE_CHK) && (div_st.rem != '0);
            div_st   = '0;
        end
        div_results_q.push_back(res);
    endfunction

    task automatic add_word(input logic b, input logic last, input logic mode);
        in_word_t w;
        w.data_bit = b;
        w.last     = last;
        w.mode     = mode;
        bits_to_send.push_back(w);
        n_queued++;
    endtask

    // Register write; the bench copy follows once the DUT has taken it
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_POLY_LOW_BITS) gen_low = val;
        else gen_len = val[LEN_W-1:0];
        n_cfg_writes++;
    endtask

    // Wait until every queued word is sent and every result has arrived
    task automatic wait_idle();
        while (bits_to_send.size() != 0 || div_results_q.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        n_phases++;
    endtask

    // One random run: generate message, check codeword (maybe corrupted), or noise
    task automatic queue_run();
        logic       msg[$];
        div_state_t s;
        logic       q, qv;
        int         kind, m, w, flip, n;
        kind = $urandom_range(0, 99);
        m    = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 16) : $urandom_range(17, 48);
        w    = eff_width(gen_len);
        for (int i = 0; i < m; i++) msg.push_back(rand_bit());
        if (kind < 45) begin
            foreach (msg[i])
                add_word(msg[i], i == m - 1, (i == m - 1) ? MODE_GEN : rand_bit());
        end else if (kind < 80) begin
            // append the remainder of the message, top bit first
            s = '0;
            foreach (msg[i]) s = div_step(s, msg[i], gen_low, gen_len, q, qv);
            for (int i = 0; i < w; i++) s = div_step(s, 1'b0, gen_low, gen_len, q, qv);
            for (int i = w - 1; i >= 0; i--) msg.push_back(s.rem[i]);
            if ($urandom_range(0, 2) == 0) begin
                flip      = $urandom_range(0, msg.size() - 1);
                msg[flip] = ~msg[flip];
            end
            n = msg.size();
            foreach (msg[i])
                add_word(msg[i], i == n - 1, (i == n - 1) ? MODE_CHK : rand_bit());
        end else begin
            // noise, sometimes leaving the run open
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                add_word(rand_bit(), (i == n - 1) && ($urandom_range(0, 9) < 7), rand_bit());
        end
    endtask

    // Input driver
    always @(posedge i_clk) begin
        in_word_t w;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && !o_s_tready) begin
            // hold the word until taken
        end else if (gap_left > 0) begin
            i_s_tvalid <= 1'b0;
            gap_left = gap_left - 1;
        end else if (bits_to_send.size() != 0) begin
            w = bits_to_send.pop_front();
            i_s_tdata  <= {{(S_TDATA_W-1){1'b0}}, w.data_bit};
            i_s_tlast  <= w.last;
            i_s_tuser  <= w.mode;
            i_s_tvalid <= 1'b1;
            gap_left = src_gaps ? pick_idle() : 0;
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    // Output ready with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            i_m_tready <= 1'b1;
            if (snk_stalls && $urandom_range(0, 4) == 0) stall_left = pick_idle();
        end
    end

    // Monitor: predict on input handshakes, check on output handshakes
    always @(posedge i_clk) begin
        div_result_t got;
        div_result_t want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                predict_division(i_s_tdata[0], i_s_tlast, i_s_tuser);
                n_words_in++;
            end
            if (o_m_tvalid && i_m_tready) begin
                got.q       = o_m_tdata[0];
                got.q_valid = o_m_tdata[1];
                got.rem     = o_m_tdata[REM_W+1:2];
                got.done    = o_m_tlast;
                got.err     = o_m_tuser;
                n_words_out++;
                if (got.done) n_runs++;
                if (got.done && got.err) n_flagged++;
                if (div_results_q.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display("[%0t] unexpected output word: q=%0b qv=%0b rem=%h done=%0b err=%0b",
                                 $realtime, got.q, got.q_valid, got.rem, got.done, got.err);
                end else begin
                    want = div_results_q.pop_front();
                    if (got.q !== want.q || got.q_valid !== want.q_valid ||
                        got.rem !== want.rem || got.done !== want.done ||
                        got.err !== want.err) begin
                        n_mismatch++;
                        if (n_mismatch <= MAX_REPORTS) begin
                            $display("[%0t] output word %0d mismatch", $realtime, n_words_out);
                            $display("    expected q=%0b qv=%0b rem=%h done=%0b err=%0b",
                                     want.q, want.q_valid, want.rem, want.done, want.err);
                            $display("    actual   q=%0b qv=%0b rem=%h done=%0b err=%0b",
                                     got.q, got.q_valid, got.rem, got.done, got.err);
                        end
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("run stopped at cycle limit, %0d results outstanding",
                     div_results_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int r;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset generator: single-bit generate, short check runs, a short message
        add_word(1'b1, 1'b1, MODE_GEN);
        add_word(1'b1, 1'b1, MODE_CHK);
        add_word(1'b0, 1'b1, MODE_CHK);
        add_word(1'b1, 1'b0, MODE_CHK);
        add_word(1'b0, 1'b0, MODE_GEN);
        add_word(1'b1, 1'b0, MODE_CHK);
        add_word(1'b1, 1'b1, MODE_GEN);
        wait_idle();

        // Shortest generator, all-zero low bits
        write_reg(REG_POLY_LEN, 32'd2);
        write_reg(REG_POLY_LOW_BITS, 32'h0000_0000);
        add_word(1'b1, 1'b0, MODE_GEN);
        add_word(1'b1, 1'b0, MODE_GEN);
        add_word(1'b0, 1'b0, MODE_CHK);
        add_word(1'b1, 1'b1, MODE_CHK);
        add_word(1'b1, 1'b1, MODE_GEN);
        wait_idle();

        // Longest generator, all-ones low bits
        write_reg(REG_POLY_LEN, 32'd33);
        write_reg(REG_POLY_LOW_BITS, 32'hFFFF_FFFF);
        add_word(1'b1, 1'b0, MODE_CHK);
        add_word(1'b0, 1'b1, MODE_GEN);
        wait_idle();

        // Length below range is taken as two
        write_reg(REG_POLY_LEN, 32'd0);
        write_reg(REG_POLY_LOW_BITS, 32'h0000_0001);
        add_word(1'b1, 1'b0, MODE_GEN);
        add_word(1'b0, 1'b0, MODE_GEN);
        add_word(1'b1, 1'b1, MODE_CHK);
        wait_idle();

        // Length above range is taken as the maximum; leave a run open
        write_reg(REG_POLY_LEN, 32'd63);
        write_reg(REG_POLY_LOW_BITS, 32'h04C1_1DB7);
        add_word(1'b1, 1'b1, MODE_GEN);
        add_word(1'b1, 1'b0, MODE_GEN);
        add_word(1'b1, 1'b0, MODE_CHK);
        add_word(1'b0, 1'b0, MODE_GEN);
        wait_idle();

        // Shorter generator while the run is still open
        write_reg(REG_POLY_LEN, 32'd5);
        write_reg(REG_POLY_LOW_BITS, 32'h0000_0003);
        add_word(1'b1, 1'b0, MODE_CHK);
        add_word(1'b0, 1'b1, MODE_GEN);
        wait_idle();

        // Random phases until the word budget is used
        while (n_queued < TOTAL_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 8) write_reg(REG_POLY_LEN, $urandom_range(34, 63));
            else if (r < 12) write_reg(REG_POLY_LEN, $urandom_range(0, 1));
            else if (r < 22) write_reg(REG_POLY_LEN, 32'd33);
            else if (r < 32) write_reg(REG_POLY_LEN, 32'd2);
            else write_reg(REG_POLY_LEN, $urandom_range(3, 20));
            r = $urandom_range(0, 99);
            if (r < 10) write_reg(REG_POLY_LOW_BITS, 32'h0000_0000);
            else if (r < 20) write_reg(REG_POLY_LOW_BITS, 32'hFFFF_FFFF);
            else if (r < 80) write_reg(REG_POLY_LOW_BITS, $urandom());

            // some phases run with no idle cycles at all
            if ($urandom_range(0, 3) == 0) begin
                src_gaps   = 1'b0;
                snk_stalls = 1'b0;
            end else begin
                src_gaps   = rand_bit();
                snk_stalls = rand_bit();
            end

            r = $urandom_range(2, 5);
            for (int i = 0; i < r; i++) queue_run();
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        $display("%0d input words, %0d output words, %0d completed runs (%0d flagged)",
                 n_words_in, n_words_out, n_runs, n_flagged);
        $display("%0d phases, %0d register writes, %0d mismatches",
                 n_phases, n_cfg_writes, n_mismatch);
        if (n_mismatch == 0 && div_results_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ crc_polynomial_divider.f @@
rtl/crcpd_pkg.sv
rtl/crcpd_front.sv
rtl/crcpd_back.sv
rtl/crc_polynomial_divider.sv
rtl/crcpd_checker.sv
tb/tb_crc_polynomial_divider.sv
